### rtl/tbb3d_pkg.sv
// shared widths, register indexes and word types of the 3d threshold bounding box
package tbb3d_pkg;

    localparam int COORD_W   = 13;
    localparam int SAMPLE_W  = 16;
    localparam int MARGIN_W  = 12;
    localparam int CFG_IDX_W = 3;
    localparam int NUM_AXES  = 3;
    localparam int MAX_DIM   = 4096;

    typedef logic [COORD_W-1:0] coord_t;
    typedef coord_t [NUM_AXES-1:0] point_t;

    localparam int CFG_DATA_W = $bits(point_t);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_THRESHOLD  = 3'd0,
        CFG_MARGIN     = 3'd1,
        CFG_SIZE_X     = 3'd2,
        CFG_SIZE_Y     = 3'd3,
        CFG_SIZE_Z     = 3'd4,
        CFG_SCAN_START = 3'd5,
        CFG_SCAN_END   = 3'd6
    } cfg_index_t;

    // corners of one finished scan, before widening
    typedef struct packed {
        point_t low;
        point_t high;
        logic   hit;
    } corners_t;

    // one result word
    typedef struct packed {
        point_t box_lo;
        point_t box_hi;
        logic   found;
    } box_t;

endpackage

### rtl/tbb3d_box_calc.sv
// turns the scan corners into the output box: max plus one, margin widening and clamping
module tbb3d_box_calc (
    input  tbb3d_pkg::corners_t                    corners,
    input  logic [tbb3d_pkg::MARGIN_W-1:0]         margin,
    input  tbb3d_pkg::point_t                      sizes,
    output tbb3d_pkg::box_t                        box
);

    always_comb
    begin
        logic [tbb3d_pkg::COORD_W:0]   hi_p1;
        logic [tbb3d_pkg::COORD_W+1:0] hi_wide;
        logic [tbb3d_pkg::COORD_W-1:0] m_ext;
        box = '0;
        box.found = corners.hit;
        m_ext = tbb3d_pkg::COORD_W'(margin);
        for (int a = 0; a < tbb3d_pkg::NUM_AXES; a++)
        begin
            hi_p1 = {1'b0, corners.high[a]} + (tbb3d_pkg::COORD_W+1)'(1);
            hi_wide = {1'b0, hi_p1} + (tbb3d_pkg::COORD_W+2)'(margin);
            if (margin == '0)
            begin
                box.box_lo[a] = corners.low[a];
                box.box_hi[a] = hi_p1[tbb3d_pkg::COORD_W-1:0];
            end
            else
            begin
                // lower edge floors at zero
                box.box_lo[a] = (corners.low[a] >= m_ext) ? corners.low[a] - m_ext : '0;
                // upper edge clamps to the volume size as written
                if (hi_wide > (tbb3d_pkg::COORD_W+2)'(sizes[a]))
                    box.box_hi[a] = sizes[a];
                else
                    box.box_hi[a] = hi_wide[tbb3d_pkg::COORD_W-1:0];
            end
        end
    end

endmodule

### rtl/threshold_bounding_box_3d_core.sv
// Threshold bounding box over a streamed 3D scan box. One voxel word is taken per unstalled
// clock and the voxel position is counted internally in raster order (x fastest) over
// [scan_start, scan_end). After the last voxel one result word gives the box of present
// voxels with sample >= threshold (from = min, to = max + 1), widened by margin and
// clamped to [0, size] when margin is nonzero; with no hit it gives, before widening,
// from = scan end, to = scan start + 1, found_any = 0. An empty scan box answers every
// voxel with that no-hit word. Throughput is one voxel per unstalled cycle: the compare,
// min/max update and position step sit between the input and a corner register, and the
// widening and clamp sit between that register and the output register. A two-word output
// buffer (output register plus skid) keeps the input open while a result waits; input
// stalls only when both words are held. Writing scan_start or scan_end restarts the scan.
module threshold_bounding_box_3d_core (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // configuration
    input  logic                                   cfg_wr_en,
    input  logic [tbb3d_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  logic [tbb3d_pkg::CFG_DATA_W-1:0]       cfg_data,
    // voxel input
    input  logic                                   in_valid,
    output logic                                   in_stall,
    input  logic signed [tbb3d_pkg::SAMPLE_W-1:0]  sample,
    input  logic                                   present,
    // box output
    output logic                                   out_valid,
    input  logic                                   out_stall,
    output logic [tbb3d_pkg::COORD_W-1:0]          box_from_x,
    output logic [tbb3d_pkg::COORD_W-1:0]          box_from_y,
    output logic [tbb3d_pkg::COORD_W-1:0]          box_from_z,
    output logic [tbb3d_pkg::COORD_W-1:0]          box_to_x,
    output logic [tbb3d_pkg::COORD_W-1:0]          box_to_y,
    output logic [tbb3d_pkg::COORD_W-1:0]          box_to_z,
    output logic                                   found_any
);

    logic signed [tbb3d_pkg::SAMPLE_W-1:0] threshold_reg;
    logic [tbb3d_pkg::MARGIN_W-1:0]        margin_reg;
    tbb3d_pkg::point_t                     size_reg;
    tbb3d_pkg::point_t                     scan_start_reg;
    tbb3d_pkg::point_t                     scan_end_reg;

    tbb3d_pkg::point_t                     pos_reg, pos_next;
    tbb3d_pkg::point_t                     low_reg, low_next;
    tbb3d_pkg::point_t                     high_reg, high_next;
    logic                                  hit_reg, hit_next;

    tbb3d_pkg::corners_t                   pend_reg, pend_next;
    logic                                  pend_valid_reg, pend_valid_next;
    tbb3d_pkg::box_t                       pend_box;

    tbb3d_pkg::box_t                       out_reg, out_next;
    logic                                  out_valid_reg, out_valid_next;
    tbb3d_pkg::box_t                       skid_reg, skid_next;
    logic                                  skid_valid_reg, skid_valid_next;

    logic                                  in_accept;
    logic                                  box_empty;
    logic                                  qualify;
    logic                                  last_voxel;
    logic                                  emit;
    logic                                  out_free;
    logic                                  pend_take;

    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !in_stall;

    assign box_empty = (scan_end_reg[0] <= scan_start_reg[0]) ||
                       (scan_end_reg[1] <= scan_start_reg[1]) ||
                       (scan_end_reg[2] <= scan_start_reg[2]);
    assign qualify   = present && (sample >= threshold_reg);

    // voxel step: corner update, position advance, end of scan
    always_comb
    begin
        tbb3d_pkg::point_t low_upd;
        tbb3d_pkg::point_t high_upd;
        logic              hit_upd;
        logic [2:0]        wrap;
        low_upd   = low_reg;
        high_upd  = high_reg;
        hit_upd   = hit_reg;
        if (qualify)
        begin
            for (int a = 0; a < tbb3d_pkg::NUM_AXES; a++)
            begin
                if (pos_reg[a] < low_reg[a])
                    low_upd[a] = pos_reg[a];
                if (pos_reg[a] > high_reg[a])
                    high_upd[a] = pos_reg[a];
            end
            hit_upd = 1'b1;
        end
        for (int a = 0; a < tbb3d_pkg::NUM_AXES; a++)
            wrap[a] = ({1'b0, pos_reg[a]} + (tbb3d_pkg::COORD_W+1)'(1)) >=
                      {1'b0, scan_end_reg[a]};
        last_voxel = &wrap;

        pos_next = pos_reg;
        if (!wrap[0])
            pos_next[0] = pos_reg[0] + tbb3d_pkg::COORD_W'(1);
        else
        begin
            pos_next[0] = scan_start_reg[0];
            if (!wrap[1])
                pos_next[1] = pos_reg[1] + tbb3d_pkg::COORD_W'(1);
            else
            begin
                pos_next[1] = scan_start_reg[1];
                if (!wrap[2])
                    pos_next[2] = pos_reg[2] + tbb3d_pkg::COORD_W'(1);
            end
        end

        low_next  = low_reg;
        high_next = high_reg;
        hit_next  = hit_reg;
        emit      = 1'b0;
        pend_next = pend_reg;

        if (in_accept)
        begin
            if (box_empty)
            begin
                emit           = 1'b1;
                pend_next.low  = scan_end_reg;
                pend_next.high = scan_start_reg;
                pend_next.hit  = 1'b0;
                pos_next       = scan_start_reg;
                low_next       = scan_end_reg;
                high_next      = scan_start_reg;
                hit_next       = 1'b0;
            end
            else if (last_voxel)
            begin
                emit           = 1'b1;
                pend_next.low  = low_upd;
                pend_next.high = high_upd;
                pend_next.hit  = hit_upd;
                pos_next       = scan_start_reg;
                low_next       = scan_end_reg;
                high_next      = scan_start_reg;
                hit_next       = 1'b0;
            end
            else
            begin
                low_next  = low_upd;
                high_next = high_upd;
                hit_next  = hit_upd;
            end
        end
        else
            pos_next = pos_reg;

        // a new scan box restarts the scan
        if (cfg_wr_en)
        begin
            unique case (tbb3d_pkg::cfg_index_t'(cfg_index))
                tbb3d_pkg::CFG_SCAN_START:
                begin
                    pos_next  = cfg_data;
                    high_next = cfg_data;
                    low_next  = scan_end_reg;
                    hit_next  = 1'b0;
                end
                tbb3d_pkg::CFG_SCAN_END:
                begin
                    pos_next  = scan_start_reg;
                    high_next = scan_start_reg;
                    low_next  = cfg_data;
                    hit_next  = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    tbb3d_box_calc u_box_calc (
        .corners (pend_reg),
        .margin  (margin_reg),
        .sizes   (size_reg),
        .box     (pend_box)
    );

    // output register with a skid word behind it
    always_comb
    begin
        out_free        = !out_valid_reg || !out_stall;
        pend_take       = pend_valid_reg && (out_free || !skid_valid_reg);
        out_next        = out_reg;
        out_valid_next  = out_valid_reg;
        skid_next       = skid_reg;
        skid_valid_next = skid_valid_reg;
        if (out_free)
        begin
            if (skid_valid_reg)
            begin
                out_next        = skid_reg;
                out_valid_next  = 1'b1;
                skid_next       = pend_box;
                skid_valid_next = pend_valid_reg;
            end
            else
            begin
                out_next       = pend_box;
                out_valid_next = pend_valid_reg;
            end
        end
        else if (!skid_valid_reg && pend_valid_reg)
        begin
            skid_next       = pend_box;
            skid_valid_next = 1'b1;
        end
        pend_valid_next = emit || (pend_valid_reg && !pend_take);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg  <= '0;
            margin_reg     <= '0;
            size_reg       <= {tbb3d_pkg::NUM_AXES{tbb3d_pkg::COORD_W'(tbb3d_pkg::MAX_DIM)}};
            scan_start_reg <= '0;
            scan_end_reg   <= '0;
            pos_reg        <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            hit_reg        <= 1'b0;
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                unique case (tbb3d_pkg::cfg_index_t'(cfg_index))
                    tbb3d_pkg::CFG_THRESHOLD:
                        threshold_reg <= cfg_data[tbb3d_pkg::SAMPLE_W-1:0];
                    tbb3d_pkg::CFG_MARGIN:
                        margin_reg <= cfg_data[tbb3d_pkg::MARGIN_W-1:0];
                    tbb3d_pkg::CFG_SIZE_X:
                        size_reg[0] <= cfg_data[tbb3d_pkg::COORD_W-1:0];
                    tbb3d_pkg::CFG_SIZE_Y:
                        size_reg[1] <= cfg_data[tbb3d_pkg::COORD_W-1:0];
                    tbb3d_pkg::CFG_SIZE_Z:
                        size_reg[2] <= cfg_data[tbb3d_pkg::COORD_W-1:0];
                    tbb3d_pkg::CFG_SCAN_START:
                        scan_start_reg <= cfg_data;
                    tbb3d_pkg::CFG_SCAN_END:
                        scan_end_reg <= cfg_data;
                    default:
                    begin
                    end
                endcase
            end
            pos_reg        <= pos_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            hit_reg        <= hit_next;
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload words
    always_ff @(posedge clk)
    begin
        pend_reg <= pend_next;
        out_reg  <= out_next;
        skid_reg <= skid_next;
    end

    assign out_valid  = out_valid_reg;
    assign box_from_x = out_reg.box_lo[0];
    assign box_from_y = out_reg.box_lo[1];
    assign box_from_z = out_reg.box_lo[2];
    assign box_to_x   = out_reg.box_hi[0];
    assign box_to_y   = out_reg.box_hi[1];
    assign box_to_z   = out_reg.box_hi[2];
    assign found_any  = out_reg.found;

`ifndef NO_ASSERTIONS
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid word held with no word in the output register");

    a_corner_order: assert property (@(posedge clk) disable iff (!rst_n)
        hit_reg |-> (low_reg[0] <= high_reg[0]) && (low_reg[1] <= high_reg[1]) &&
                    (low_reg[2] <= high_reg[2]))
        else $error("low corner above high corner after a hit");

    a_pos_in_box: assert property (@(posedge clk) disable iff (!rst_n)
        !box_empty |-> (pos_reg[0] >= scan_start_reg[0]) && (pos_reg[0] < scan_end_reg[0]) &&
                       (pos_reg[2] >= scan_start_reg[2]) && (pos_reg[2] < scan_end_reg[2]))
        else $error("voxel position outside the scan box");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !box_empty && last_voxel && !cfg_wr_en) |=>
            (!hit_reg && pend_valid_reg && (pos_reg == scan_start_reg)))
        else $error("scan not restarted after its last voxel");
`endif

endmodule
